// ===== hdl/cesu8_to_utf8_converter_macros.svh =====
// Assertion macros for the CESU-8 to UTF-8 converter.
// No dependencies; included by the files that carry assertions.
`ifndef CESU8_TO_UTF8_CONVERTER_MACROS_SVH
`define CESU8_TO_UTF8_CONVERTER_MACROS_SVH

`ifndef SYNTH

// Check that cond_a implies cond_b in the same cycle.
`define CU8_ASSERT_SAME(label, clk, rst_n, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond_a) |-> (cond_b)) else $error("cu8 same-cycle check failed");

// Check that cond_a implies cond_b in the following cycle.
`define CU8_ASSERT_NEXT(label, clk, rst_n, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond_a) |=> (cond_b)) else $error("cu8 next-cycle check failed");

`else

`define CU8_ASSERT_SAME(label, clk, rst_n, cond_a, cond_b)
`define CU8_ASSERT_NEXT(label, clk, rst_n, cond_a, cond_b)

`endif

`endif

// ===== hdl/cu8_pkg.sv =====
// Shared types and constants for the CESU-8 to UTF-8 converter.
// No dependencies.
package cu8_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned WinDepth = 5;             // pending bytes kept
    localparam int unsigned WinFull  = WinDepth + 1;  // bytes seen by the pair test
    localparam int unsigned CntW     = $clog2(WinFull + 1);
    localparam int unsigned PairLen  = 4;

    localparam logic [ByteW-1:0] SurLead    = 8'hED;
    localparam logic [ByteW-1:0] HiSurTag   = 8'hA0;
    localparam logic [ByteW-1:0] LoSurTag   = 8'hB0;
    localparam logic [ByteW-1:0] NibHiMask  = 8'hF0;
    localparam logic [ByteW-1:0] ContMask   = 8'hC0;
    localparam logic [ByteW-1:0] ContTag    = 8'h80;
    localparam logic [ByteW-1:0] Lead4Tag   = 8'hF0;
    localparam logic [ByteW-1:0] PlaneMask  = 8'h1C;
    localparam logic [ByteW-1:0] MidMask    = 8'h3C;
    localparam logic [ByteW-1:0] Low2Mask   = 8'h03;
    localparam logic [ByteW-1:0] Low4Mask   = 8'h0F;

    typedef logic [CntW-1:0] cnt_t;

    typedef struct packed {
        logic [ByteW-1:0] in_byte;
        logic             in_last;
    } in_beat_t;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        logic             out_last;
    } out_beat_t;

endpackage

// ===== hdl/cesu8_to_utf8_converter.sv =====
// Top level of the CESU-8 to UTF-8 converter: pair detection and output queue.
// Depends on cu8_pkg and cesu8_to_utf8_converter_macros.svh.
//
// Converts a CESU-8 byte stream into UTF-8, one byte per beat on each side.
// Up to five bytes are held back in a window; when a sixth arrives the six are
// tested for a surrogate pair (ED Ax xx ED Bx xx) and, on a hit, replaced by
// the four-byte UTF-8 form. Otherwise the oldest byte leaves and the window
// slides. A beat with in_last set flushes whatever is still held, and the
// final output byte of that string carries out_last. Each accepted input
// beat loads its 0 to 6 result bytes in parallel into a six-entry output
// queue that drains one byte per cycle while m_ready is high. Input is taken
// while the queue is empty or holds one byte that leaves in the same cycle,
// so plain bytes pass at one per cycle when the output does not stall; a beat
// that yields n bytes (a pair gives 4, a flush up to 6) holds the input while
// the queue drains, until only one byte is left and it is leaving.
`include "cesu8_to_utf8_converter_macros.svh"

module cesu8_to_utf8_converter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cu8_pkg::in_beat_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cu8_pkg::out_beat_t m_data
);
    import cu8_pkg::*;

    // Window of held bytes; entries past the count are never read out.
    logic [ByteW-1:0] pend_reg [WinDepth];
    logic [ByteW-1:0] pend_next [WinDepth];
    cnt_t             pend_cnt_reg;
    cnt_t             pend_cnt_next;

    // Output queue, head at entry zero.
    logic [ByteW-1:0] q_byte_reg [WinFull];
    cnt_t             q_cnt_reg;
    logic             q_last_reg;

    logic [ByteW-1:0] win [WinFull];
    logic [ByteW-1:0] pair [PairLen];
    logic [ByteW-1:0] load_byte [WinFull];
    logic [ByteW-1:0] hi_plus1;
    cnt_t             win_cnt;
    cnt_t             load_cnt;
    logic             win_full;
    logic             pair_hit;
    logic             slide;
    logic             accept;
    logic             pop;

    assign accept = s_valid && s_ready;
    assign pop    = m_valid && m_ready;

    // Take a new beat when the queue is empty or its last byte leaves now.
    assign s_ready = (q_cnt_reg == '0) || ((q_cnt_reg == cnt_t'(1)) && m_ready);

    assign m_valid         = (q_cnt_reg != '0);
    assign m_data.out_byte = q_byte_reg[0];
    assign m_data.out_last = q_last_reg && (q_cnt_reg == cnt_t'(1));

    // Append the incoming byte right after the held bytes.
    always_comb begin
        for (int i = 0; i < WinDepth; i++) begin
            win[i] = (cnt_t'(i) < pend_cnt_reg) ? pend_reg[i] : s_data.in_byte;
        end
        win[WinDepth] = s_data.in_byte;
    end

    assign win_cnt  = pend_cnt_reg + cnt_t'(1);
    assign win_full = (win_cnt == cnt_t'(WinFull));

    assign pair_hit = win_full
        && (win[0] == SurLead) && ((win[1] & NibHiMask) == HiSurTag)
        && ((win[2] & ContMask) == ContTag)
        && (win[3] == SurLead) && ((win[4] & NibHiMask) == LoSurTag)
        && ((win[5] & ContMask) == ContTag);

    // Rebuild the code point bits in four-byte UTF-8 form.
    assign hi_plus1 = win[1] + ByteW'(1);
    assign pair[0]  = Lead4Tag | ((hi_plus1 & PlaneMask) >> 2);
    assign pair[1]  = ContTag | ((hi_plus1 & Low2Mask) << 4) | ((win[2] & MidMask) >> 2);
    assign pair[2]  = ContTag | ((win[2] & Low2Mask) << 4) | (win[4] & Low4Mask);
    assign pair[3]  = win[5];

    // Results are always a prefix of either the pair bytes or the window.
    always_comb begin
        for (int i = 0; i < WinFull; i++) begin
            load_byte[i] = (pair_hit && (i < PairLen)) ? pair[i] : win[i];
        end
    end

    always_comb begin
        slide = 1'b0;
        if (pair_hit) begin
            load_cnt      = cnt_t'(PairLen);
            pend_cnt_next = '0;
        end else if (win_full) begin
            slide         = !s_data.in_last;
            load_cnt      = s_data.in_last ? cnt_t'(WinFull) : cnt_t'(1);
            pend_cnt_next = s_data.in_last ? '0 : cnt_t'(WinDepth);
        end else begin
            load_cnt      = s_data.in_last ? win_cnt : '0;
            pend_cnt_next = s_data.in_last ? '0 : win_cnt;
        end
        for (int i = 0; i < WinDepth; i++) begin
            pend_next[i] = slide ? win[i+1] : win[i];
        end
    end

    // Window payload needs no reset.
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < WinDepth; i++) begin
                pend_reg[i] <= pend_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_cnt_reg <= '0;
        end else if (accept) begin
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    // Load the queue on accept, else advance it on a taken output beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg  <= '0;
            q_last_reg <= 1'b0;
        end else if (accept) begin
            q_cnt_reg  <= load_cnt;
            q_last_reg <= s_data.in_last;
        end else if (pop) begin
            q_cnt_reg  <= q_cnt_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < WinFull; i++) begin
                q_byte_reg[i] <= load_byte[i];
            end
        end else if (pop) begin
            for (int i = 0; i < WinFull - 1; i++) begin
                q_byte_reg[i] <= q_byte_reg[i+1];
            end
        end
    end

    // Input must stall while more than one queued byte remains.
    `CU8_ASSERT_SAME(a_stall_on_backlog, aclk, aresetn, q_cnt_reg > cnt_t'(1), !s_ready)
    // The window never holds more than five bytes.
    `CU8_ASSERT_SAME(a_pend_bound, aclk, aresetn, 1'b1, pend_cnt_reg <= cnt_t'(WinDepth))
    // A string's final byte leaves only after the window was emptied.
    `CU8_ASSERT_SAME(a_last_empty_win, aclk, aresetn, m_valid && m_data.out_last,
                     pend_cnt_reg == '0)
    // A matched pair loads exactly four bytes.
    `CU8_ASSERT_NEXT(a_pair_four, aclk, aresetn, accept && pair_hit,
                     q_cnt_reg == cnt_t'(PairLen))

endmodule
